>>> rtl/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude stream.
package sgm_pkg;

   localparam int CSR_BITS = 13;
   localparam logic [CSR_BITS-1:0] ROW_WIDTH_RESET = 13'd256;
   localparam int MIN_ROW_WIDTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ0,
      ST_READ1,
      ST_READ2,
      ST_DRAIN,
      ST_CALC
   } sgm_state_type;

   typedef struct packed {
      logic shift;
      logic use_first;
   } sgm_row_ctrl_type;

endpackage

>>> rtl/sgm_ram.sv
// Generic RAM: one write port, two registered read ports.
module sgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8195
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/sgm_window_row.sv
// One row of the 3x3 window: three sample cells that shift toward the far end.
module sgm_window_row import sgm_pkg::*; #(
   parameter int VOXEL_BITS = 16
) (
   input  logic                         clock,
   input  sgm_row_ctrl_type             ctrl,
   input  logic signed [VOXEL_BITS-1:0] data_in,
   input  logic signed [VOXEL_BITS-1:0] first_voxel,
   output logic signed [VOXEL_BITS-1:0] tap0,
   output logic signed [VOXEL_BITS-1:0] tap1,
   output logic signed [VOXEL_BITS-1:0] tap2
);

   logic signed [VOXEL_BITS-1:0] cell_ff [3];
   logic signed [VOXEL_BITS-1:0] cell_in;

   assign cell_in = ctrl.use_first ? first_voxel : data_in;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         cell_ff[0] <= cell_in;
         cell_ff[1] <= cell_ff[0];
         cell_ff[2] <= cell_ff[1];
      end
   end

   assign tap0 = cell_ff[0];
   assign tap1 = cell_ff[1];
   assign tap2 = cell_ff[2];

endmodule

>>> rtl/sgm_root_cell.sv
// One cell of the square root chain: retires one root bit per cell.
module sgm_root_cell #(
   parameter int MAG_BITS = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [2*MAG_BITS-1:0]   in_rad,
   input  logic [MAG_BITS+1:0]     in_rem,
   input  logic [MAG_BITS-1:0]     in_root,
   output logic                    out_valid,
   output logic [2*MAG_BITS-1:0]   out_rad,
   output logic [MAG_BITS+1:0]     out_rem,
   output logic [MAG_BITS-1:0]     out_root
);

   localparam int REM_BITS = MAG_BITS + 2;
   localparam int TMP_BITS = MAG_BITS + 4;

   logic                  valid_ff;
   logic [2*MAG_BITS-1:0] rad_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [MAG_BITS-1:0]   root_ff;
   logic [TMP_BITS-1:0]   partial;
   logic [TMP_BITS-1:0]   trial;
   logic                  fits;
   logic [REM_BITS-1:0]   rem_in;
   logic [MAG_BITS-1:0]   root_in;
   logic [2*MAG_BITS-1:0] rad_in;

   always_comb begin
      partial = {in_rem, in_rad[2*MAG_BITS-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      fits    = partial >= trial;
      rem_in  = fits ? REM_BITS'(partial - trial) : REM_BITS'(partial);
      root_in = {in_root[MAG_BITS-2:0], fits};
      rad_in  = in_rad << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

>>> rtl/sgm_magnitude.sv
// Gradient sums, squares and the square root cell chain with output hold.
module sgm_magnitude #(
   parameter int VOXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         in_ready,
   input  logic signed [VOXEL_BITS-1:0] near0,
   input  logic signed [VOXEL_BITS-1:0] near1,
   input  logic signed [VOXEL_BITS-1:0] near2,
   input  logic signed [VOXEL_BITS-1:0] mid0,
   input  logic signed [VOXEL_BITS-1:0] mid2,
   input  logic signed [VOXEL_BITS-1:0] far0,
   input  logic signed [VOXEL_BITS-1:0] far1,
   input  logic signed [VOXEL_BITS-1:0] far2,
   input  logic                         out_ready,
   output logic                         out_valid,
   output logic [VOXEL_BITS+2:0]        magnitude
);

   localparam int GRAD_BITS = VOXEL_BITS + 3;
   localparam int ABS_BITS  = VOXEL_BITS + 2;
   localparam int SQ_BITS   = 2 * ABS_BITS;
   localparam int MAG_BITS  = VOXEL_BITS + 3;
   localparam int RAD_BITS  = 2 * MAG_BITS;
   localparam int REM_BITS  = MAG_BITS + 2;

   logic                        advance;
   logic signed [GRAD_BITS-1:0] gx_in;
   logic signed [GRAD_BITS-1:0] gy_in;
   logic signed [GRAD_BITS-1:0] gx_ff;
   logic signed [GRAD_BITS-1:0] gy_ff;
   logic                        grad_valid_ff;
   logic [ABS_BITS-1:0]         ax;
   logic [ABS_BITS-1:0]         ay;
   logic [SQ_BITS-1:0]          sqx_in;
   logic [SQ_BITS-1:0]          sqy_in;
   logic [SQ_BITS-1:0]          sqx_ff;
   logic [SQ_BITS-1:0]          sqy_ff;
   logic                        sq_valid_ff;
   logic [RAD_BITS-1:0]         sum_in;
   logic [RAD_BITS-1:0]         sum_ff;
   logic                        sum_valid_ff;

   logic                chain_valid [MAG_BITS];
   logic [RAD_BITS-1:0] chain_rad   [MAG_BITS];
   logic [REM_BITS-1:0] chain_rem   [MAG_BITS];
   logic [MAG_BITS-1:0] chain_root  [MAG_BITS];

   assign advance  = !out_valid || out_ready;
   assign in_ready = advance;

   always_comb begin
      gx_in = (GRAD_BITS'(far0) + (GRAD_BITS'(mid0) <<< 1) + GRAD_BITS'(near0))
            - (GRAD_BITS'(far2) + (GRAD_BITS'(mid2) <<< 1) + GRAD_BITS'(near2));
      gy_in = (GRAD_BITS'(far2) + (GRAD_BITS'(far1) <<< 1) + GRAD_BITS'(far0))
            - (GRAD_BITS'(near2) + (GRAD_BITS'(near1) <<< 1) + GRAD_BITS'(near0));
      ax     = gx_ff[GRAD_BITS-1] ? ABS_BITS'(-gx_ff) : ABS_BITS'(gx_ff);
      ay     = gy_ff[GRAD_BITS-1] ? ABS_BITS'(-gy_ff) : ABS_BITS'(gy_ff);
      sqx_in = ax * ax;
      sqy_in = ay * ay;
      sum_in = RAD_BITS'(sqx_ff) + RAD_BITS'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else if (advance) begin
         grad_valid_ff <= push;
         sq_valid_ff   <= grad_valid_ff;
         sum_valid_ff  <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sum_ff <= sum_in;
      end
   end

   assign chain_valid[0] = sum_valid_ff;
   assign chain_rad[0]   = sum_ff;
   assign chain_rem[0]   = '0;
   assign chain_root[0]  = '0;

   for (genvar k = 0; k < MAG_BITS; k++) begin : g_cell
      if (k < MAG_BITS - 1) begin : g_mid
         sgm_root_cell #(.MAG_BITS(MAG_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .in_valid (chain_valid[k]),
            .in_rad   (chain_rad[k]),
            .in_rem   (chain_rem[k]),
            .in_root  (chain_root[k]),
            .out_valid(chain_valid[k+1]),
            .out_rad  (chain_rad[k+1]),
            .out_rem  (chain_rem[k+1]),
            .out_root (chain_root[k+1])
         );
      end else begin : g_last
         sgm_root_cell #(.MAG_BITS(MAG_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .in_valid (chain_valid[k]),
            .in_rad   (chain_rad[k]),
            .in_rem   (chain_rem[k]),
            .in_root  (chain_root[k]),
            .out_valid(out_valid),
            .out_rad  (),
            .out_rem  (),
            .out_root (magnitude)
         );
      end
   end

endmodule

>>> rtl/sobel_gradient_magnitude_stream.sv
// Top level of the streaming 3x3 Sobel gradient magnitude over raster-order voxels.
//
// Send voxels in raster order, flag the first voxel of each volume with volume_start, and
// after the last voxel send row_width+1 padding requests; the first row_width+1 requests of a
// volume give no result, every later one gives floor(sqrt(Gx^2 + Gy^2)) for the voxel
// row_width+1 positions back, with neighbors taken by flat index (they wrap across rows and
// slices) and neighbors before the volume start reading the first voxel. A request that gives
// no result does not hold the next; one that gives a result is followed by three reads of the
// two-port history memory that load the two upper window rows, a drain of the read data and a
// hand-off of the window to the gradient stage, which waits while the magnitude stage stalls;
// no request is taken until the hand-off is done. Then come the gradient, square, sum and one
// square-root cell per result bit. row_width is clamped to 2..MAX_ROW_WIDTH and may only be
// written while no request is in flight. The history memory needs no clearing after reset.
module sobel_gradient_magnitude_stream import sgm_pkg::*; #(
   parameter int MAX_ROW_WIDTH = 4096,
   parameter int VOXEL_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VOXEL_BITS+7)/8)*8-1:0]       req_tdata,  // voxel
   input  logic [1:0]                            req_tuser,  // volume_start (bit 1), is_padding (bit 0)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((VOXEL_BITS+3+7)/8)*8-1:0]     rsp_tdata,  // magnitude
   input  logic                                  csr_wr_en,
   input  logic [CSR_BITS-1:0]                   csr_wr_data
);

   localparam int HIST_DEPTH = 2 * MAX_ROW_WIDTH + 3;
   localparam int AW         = $clog2(HIST_DEPTH);
   localparam int WB         = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CB         = (WB > CSR_BITS) ? WB : CSR_BITS;
   localparam int MAG_BITS   = VOXEL_BITS + 3;
   localparam int RSP_BITS   = ((VOXEL_BITS + 3 + 7) / 8) * 8;

   sgm_state_type state_ff;
   sgm_state_type state_in;

   logic [CSR_BITS-1:0]          row_width_ff;
   logic [AW-1:0]                wp_ff;
   logic [AW-1:0]                wp_in;
   logic [AW-1:0]                seen_ff;
   logic [AW-1:0]                seen_in;
   logic [AW-1:0]                n_ff;
   logic [WB-1:0]                w_ff;
   logic signed [VOXEL_BITS-1:0] first_voxel_ff;
   logic                         rd_shift_ff;
   logic                         flag_a_ff;
   logic                         flag_b_ff;

   logic                         req_accept;
   logic                         is_padding;
   logic                         volume_start;
   logic signed [VOXEL_BITS-1:0] voxel;
   logic signed [VOXEL_BITS-1:0] sample;
   logic [AW-1:0]                n_cur;
   logic [CB-1:0]                csr_ext;
   logic [WB-1:0]                w_clamp;
   logic                         result_due;
   logic                         rd_issue;
   logic [1:0]                   rd_offset;
   logic [AW-1:0]                back_a;
   logic [AW-1:0]                back_b;
   logic [AW-1:0]                rd_addr_a;
   logic [AW-1:0]                rd_addr_b;
   logic [VOXEL_BITS-1:0]        rd_data_a;
   logic [VOXEL_BITS-1:0]        rd_data_b;
   logic                         push;
   logic                         mag_ready;
   logic [MAG_BITS-1:0]          magnitude;

   sgm_row_ctrl_type             near_ctrl;
   sgm_row_ctrl_type             mid_ctrl;
   sgm_row_ctrl_type             far_ctrl;

   logic signed [VOXEL_BITS-1:0] near0, near1, near2;
   logic signed [VOXEL_BITS-1:0] mid0, mid1, mid2;
   logic signed [VOXEL_BITS-1:0] far0, far1, far2;

   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                                input logic [AW-1:0] back);
      logic [AW:0] diff;
      diff = {1'b0, wp} - {1'b0, back};
      if (diff[AW]) begin
         diff = diff + (AW+1)'(HIST_DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   assign req_accept   = req_tvalid && req_tready;
   assign is_padding   = req_tuser[0];
   assign volume_start = req_tuser[1];
   assign voxel        = signed'(req_tdata[VOXEL_BITS-1:0]);

   always_comb begin
      n_cur   = volume_start ? '0 : seen_ff;
      sample  = is_padding ? first_voxel_ff : voxel;
      seen_in = (n_cur == '1) ? n_cur : n_cur + 1'b1;
      wp_in   = (wp_ff == AW'(HIST_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      csr_ext = CB'(row_width_ff);
      if (csr_ext < CB'(MIN_ROW_WIDTH)) begin
         w_clamp = WB'(MIN_ROW_WIDTH);
      end else if (csr_ext > CB'(MAX_ROW_WIDTH)) begin
         w_clamp = WB'(MAX_ROW_WIDTH);
      end else begin
         w_clamp = WB'(csr_ext);
      end
      result_due = n_cur > AW'(w_clamp);
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      rd_offset  = 2'd0;
      push       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept && result_due) begin
               state_in = ST_READ0;
            end
         end
         ST_READ0: begin
            rd_issue  = 1'b1;
            rd_offset = 2'd2;
            state_in  = ST_READ1;
         end
         ST_READ1: begin
            rd_issue  = 1'b1;
            rd_offset = 2'd1;
            state_in  = ST_READ2;
         end
         ST_READ2: begin
            rd_issue  = 1'b1;
            rd_offset = 2'd0;
            state_in  = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            push = 1'b1;
            if (mag_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      back_a    = AW'(w_ff) + AW'(rd_offset);
      back_b    = AW'({w_ff, 1'b0}) + AW'(rd_offset);
      rd_addr_a = ring_addr(wp_ff, back_a);
      rd_addr_b = ring_addr(wp_ff, back_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_width_ff   <= ROW_WIDTH_RESET;
         wp_ff          <= '0;
         seen_ff        <= '0;
         first_voxel_ff <= '0;
         rd_shift_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_shift_ff <= rd_issue;
         if (csr_wr_en) begin
            row_width_ff <= csr_wr_data;
         end
         if (req_accept) begin
            wp_ff   <= wp_in;
            seen_ff <= seen_in;
            if (n_cur == '0 && !is_padding) begin
               first_voxel_ff <= voxel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         n_ff <= n_cur;
         w_ff <= w_clamp;
      end
      flag_a_ff <= back_a > n_ff;
      flag_b_ff <= back_b > n_ff;
   end

   sgm_ram #(
      .WIDTH(VOXEL_BITS),
      .DEPTH(HIST_DEPTH)
   ) u_history (
      .clock    (clock),
      .wr_en    (req_accept),
      .wr_addr  (wp_in),
      .wr_data  (sample),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign near_ctrl = '{shift: req_accept, use_first: is_padding};
   assign mid_ctrl  = '{shift: rd_shift_ff, use_first: flag_a_ff};
   assign far_ctrl  = '{shift: rd_shift_ff, use_first: flag_b_ff};

   sgm_window_row #(.VOXEL_BITS(VOXEL_BITS)) u_near (
      .clock      (clock),
      .ctrl       (near_ctrl),
      .data_in    (voxel),
      .first_voxel(first_voxel_ff),
      .tap0       (near0),
      .tap1       (near1),
      .tap2       (near2)
   );

   sgm_window_row #(.VOXEL_BITS(VOXEL_BITS)) u_mid (
      .clock      (clock),
      .ctrl       (mid_ctrl),
      .data_in    (signed'(rd_data_a)),
      .first_voxel(first_voxel_ff),
      .tap0       (mid0),
      .tap1       (mid1),
      .tap2       (mid2)
   );

   sgm_window_row #(.VOXEL_BITS(VOXEL_BITS)) u_far (
      .clock      (clock),
      .ctrl       (far_ctrl),
      .data_in    (signed'(rd_data_b)),
      .first_voxel(first_voxel_ff),
      .tap0       (far0),
      .tap1       (far1),
      .tap2       (far2)
   );

   sgm_magnitude #(.VOXEL_BITS(VOXEL_BITS)) u_magnitude (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_ready (mag_ready),
      .near0    (near0),
      .near1    (near1),
      .near2    (near2),
      .mid0     (mid0),
      .mid2     (mid2 ^ (mid1 & '0)),
      .far0     (far0),
      .far1     (far1),
      .far2     (far2),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .magnitude(magnitude)
   );

   assign rsp_tdata = RSP_BITS'(magnitude);

endmodule
